// ===== rtl/i2cbm_pkg.sv =====
`default_nettype none

package i2cbm_pkg;

  localparam int unsigned DIVIDER_BITS_DEF = 16;
  localparam int unsigned TPU_W            = 16;
  localparam int unsigned BYTE_W           = 8;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e_t;

  // one tick as it sits in the queue, already decoded
  typedef struct packed {
    logic              start;
    cmd_e_t            cmd;
    logic [BYTE_W-1:0] wr_byte;
    logic              ack_after_read;
    logic              sda_in;
  } tick_item_t;

  typedef struct packed {
    logic       valid;
    tick_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

// ===== rtl/i2cbm_if.sv =====
`default_nettype none

interface i2cbm_tick_if;
  import i2cbm_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd_valid;
  logic [1:0]        mode;
  logic [BYTE_W-1:0] wr_byte;
  logic              ack_after_read;
  logic              sda_in;
  modport source (output valid, cmd_valid, mode, wr_byte, ack_after_read, sda_in,
                  input ready);
  modport sink (input valid, cmd_valid, mode, wr_byte, ack_after_read, sda_in,
                output ready);
endinterface

interface i2cbm_res_if;
  import i2cbm_pkg::*;
  logic              valid;
  logic              ready;
  logic              scl_low;
  logic              sda_low;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rd_byte;
  logic              ack_bit;
  modport source (output valid, scl_low, sda_low, busy_res, done_res, rd_byte, ack_bit,
                  input ready);
  modport sink (input valid, scl_low, sda_low, busy_res, done_res, rd_byte, ack_bit,
                output ready);
endinterface

interface i2cbm_cfg_if;
  import i2cbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [TPU_W-1:0] ticks_per_unit;
  modport source (output valid, ticks_per_unit, input ready);
  modport sink (input valid, ticks_per_unit, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2c_bit_level_master.sv =====
// channel | dir | payload                                          | accepted when
// tick    | in  | cmd_valid, mode, wr_byte, ack_after_read, sda_in | valid && ready
// res     | out | scl_low, sda_low, busy_res, done_res, rd_byte,   | valid && ready
//         |     | ack_bit                                          |
// cfg     | in  | ticks_per_unit                                   | valid && ready
//
// one tick per clock sustained while results are taken; a tick's result is registered
// first in the two-entry tick queue, then in the bus engine's state update
// synchronous reset releases both lines and empties the queue; cfg is always ready
// a stalled result holds the engine; the queue keeps taking ticks until it is full

`default_nettype none

module i2c_bit_level_master #(
  parameter int unsigned DIVIDER_BITS = i2cbm_pkg::DIVIDER_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  i2cbm_tick_if.sink  tick,
  i2cbm_res_if.source res,
  i2cbm_cfg_if.sink   cfg
);
  import i2cbm_pkg::*;

  q_head_t head;
  logic    pop;

  i2cbm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .head (head),
    .pop  (pop)
  );

  i2cbm_engine #(
    .DIVIDER_BITS (DIVIDER_BITS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .cfg  (cfg),
    .res  (res)
  );

endmodule

`default_nettype wire

// ===== rtl/i2cbm_front.sv =====
`default_nettype none

module i2cbm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  i2cbm_tick_if.sink             tick,
  output i2cbm_pkg::q_head_t     head,
  input  wire logic              pop
);
  import i2cbm_pkg::*;

  localparam int unsigned DEPTH = 2;

  tick_item_t     entry [DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;
  tick_item_t     decoded;
  logic           push;
  logic           do_pop;

  always_comb begin
    decoded.start          = tick.cmd_valid;
    decoded.wr_byte        = tick.wr_byte;
    decoded.ack_after_read = tick.ack_after_read;
    decoded.sda_in         = tick.sda_in;
    unique case (tick.mode)
      2'd0:    decoded.cmd = CMD_START;
      2'd1:    decoded.cmd = CMD_STOP;
      2'd2:    decoded.cmd = CMD_WRITE;
      default: decoded.cmd = CMD_READ;
    endcase
  end

  assign tick.ready = (count != 2'(DEPTH));
  assign push       = tick.valid && tick.ready;
  assign do_pop     = pop && (count != 2'd0);

  always_comb begin
    count_next = count;
    if (push && !do_pop) begin
      count_next = count + 2'd1;
    end else if (!push && do_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
  end

  assign head = {(count != 2'd0), entry[rd_ptr]};

endmodule

`default_nettype wire

// ===== rtl/i2cbm_engine.sv =====
`default_nettype none

module i2cbm_engine #(
  parameter int unsigned DIVIDER_BITS = i2cbm_pkg::DIVIDER_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire i2cbm_pkg::q_head_t head,
  output logic                   pop,
  i2cbm_cfg_if.sink              cfg,
  i2cbm_res_if.source            res
);
  import i2cbm_pkg::*;

  localparam int unsigned CW = (DIVIDER_BITS + 1 > TPU_W + 1) ? DIVIDER_BITS + 1 : TPU_W + 1;
  localparam logic [4:0] WR_BIT_PHASES = 5'd24;
  localparam logic [4:0] RD_BIT_PHASES = 5'd16;
  localparam logic [4:0] RD_ACK_END    = 5'd19;
  localparam logic [1:0] SUB_LAST      = 2'd2;
  localparam int unsigned L_SCL = 0;
  localparam int unsigned L_SDA = 1;

  function automatic logic [4:0] phase_count(cmd_e_t c);
    logic [4:0] n;
    unique case (c)
      CMD_START: n = 5'd3;
      CMD_STOP:  n = 5'd2;
      CMD_WRITE: n = 5'd26;
      default:   n = 5'd20;
    endcase
    return n;
  endfunction

  // one bit slot: data with the clock high, then the clock low, then sda held low after a one
  function automatic logic [1:0] bit_slot(logic [1:0] sub, logic one, logic [1:0] line);
    logic [1:0] l;
    l = line;
    if (sub == 2'd0) begin
      l = one ? 2'b00 : 2'b10;
    end else if (sub == 2'd1) begin
      l[L_SCL] = 1'b1;
    end else if (one) begin
      l[L_SDA] = 1'b1;
    end
    return l;
  endfunction

  function automatic logic [1:0] phase_lines(cmd_e_t c, logic [4:0] p, logic [1:0] sub,
                                             logic msb, logic ach, logic [1:0] line);
    logic [1:0] l;
    l = line;
    unique case (c)
      CMD_START: begin
        if (p == 5'd0) l = 2'b00;
        else if (p == 5'd1) l[L_SDA] = 1'b1;
        else l[L_SCL] = 1'b1;
      end
      CMD_STOP: begin
        if (p == 5'd0) l[L_SCL] = 1'b0;
        else l[L_SDA] = 1'b0;
      end
      CMD_WRITE: begin
        if (p < WR_BIT_PHASES) l = bit_slot(sub, msb, line);
        else if (p == WR_BIT_PHASES) l = 2'b00;
        else l[L_SCL] = 1'b1;
      end
      default: begin
        if (p < RD_BIT_PHASES) begin
          if (!p[0]) l = 2'b00;
          else l[L_SCL] = 1'b1;
        end else if (p < RD_ACK_END) begin
          l = bit_slot(p[1:0], !ach, line);
        end
      end
    endcase
    return l;
  endfunction

  logic [TPU_W-1:0]        tpu;
  logic                    active;
  cmd_e_t                  cur_cmd;
  logic [4:0]              phase_index;
  logic [1:0]              sub;
  logic [DIVIDER_BITS-1:0] tick_divider;
  logic [BYTE_W-1:0]       shift_reg;
  logic                    ack_choice;
  logic                    ack_sample;
  logic [1:0]              line_drive;
  logic [BYTE_W-1:0]       rd_hold;

  logic                    active_next;
  cmd_e_t                  cur_cmd_next;
  logic [4:0]              phase_index_next;
  logic [1:0]              sub_next;
  logic [DIVIDER_BITS-1:0] tick_divider_next;
  logic [BYTE_W-1:0]       shift_reg_next;
  logic                    ack_choice_next;
  logic                    ack_sample_next;
  logic [1:0]              line_drive_next;
  logic [BYTE_W-1:0]       rd_hold_next;
  logic                    done_next;

  logic                    res_valid;
  logic                    step;
  tick_item_t              it;

  assign it        = head.item;
  assign step      = head.valid && (!res_valid || res.ready);
  assign pop       = step;
  assign cfg.ready = 1'b1;

  always_comb begin
    logic [DIVIDER_BITS:0] cnt;
    logic [TPU_W-1:0]      tpu_eff;
    logic                  phase_end;

    active_next       = active;
    cur_cmd_next      = cur_cmd;
    phase_index_next  = phase_index;
    sub_next          = sub;
    tick_divider_next = tick_divider;
    shift_reg_next    = shift_reg;
    ack_choice_next   = ack_choice;
    ack_sample_next   = ack_sample;
    line_drive_next   = line_drive;
    rd_hold_next      = rd_hold;
    done_next         = 1'b0;

    if (!active && it.start) begin
      active_next       = 1'b1;
      cur_cmd_next      = it.cmd;
      phase_index_next  = 5'd0;
      sub_next          = 2'd0;
      tick_divider_next = '0;
      shift_reg_next    = (it.cmd == CMD_WRITE) ? it.wr_byte : '0;
      ack_choice_next   = it.ack_after_read;
      line_drive_next   = phase_lines(it.cmd, 5'd0, 2'd0, shift_reg_next[BYTE_W-1],
                                      it.ack_after_read, line_drive);
    end

    cnt       = {1'b0, tick_divider_next} + {{DIVIDER_BITS{1'b0}}, 1'b1};
    tpu_eff   = (tpu == '0) ? TPU_W'(1) : tpu;
    // a phase also closes when the divider would overflow
    phase_end = (CW'(cnt) >= CW'(tpu_eff)) || cnt[DIVIDER_BITS];

    if (active_next) begin
      if (phase_end) begin
        if (cur_cmd_next == CMD_WRITE) begin
          if (phase_index_next < WR_BIT_PHASES && sub_next == SUB_LAST) begin
            shift_reg_next = {shift_reg_next[BYTE_W-2:0], 1'b0};
          end else if (phase_index_next == WR_BIT_PHASES) begin
            ack_sample_next = it.sda_in;
          end
        end else if (cur_cmd_next == CMD_READ) begin
          if (phase_index_next < RD_BIT_PHASES && !phase_index_next[0]) begin
            shift_reg_next = {shift_reg_next[BYTE_W-2:0], it.sda_in};
          end
        end
        tick_divider_next = '0;
        phase_index_next  = phase_index_next + 5'd1;
        sub_next          = (sub_next == SUB_LAST) ? 2'd0 : sub_next + 2'd1;
        if (phase_index_next >= phase_count(cur_cmd_next)) begin
          if (cur_cmd_next == CMD_READ) begin
            rd_hold_next = shift_reg_next;
          end
          active_next      = 1'b0;
          phase_index_next = 5'd0;
          done_next        = 1'b1;
        end else begin
          line_drive_next = phase_lines(cur_cmd_next, phase_index_next, sub_next,
                                        shift_reg_next[BYTE_W-1], ack_choice_next,
                                        line_drive_next);
        end
      end else begin
        tick_divider_next = cnt[DIVIDER_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tpu          <= TPU_W'(1);
      active       <= 1'b0;
      cur_cmd      <= CMD_START;
      phase_index  <= 5'd0;
      sub          <= 2'd0;
      tick_divider <= '0;
      shift_reg    <= '0;
      ack_choice   <= 1'b0;
      ack_sample   <= 1'b1;
      line_drive   <= 2'b00;
      rd_hold      <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        tpu <= cfg.ticks_per_unit;
      end
      if (step) begin
        active       <= active_next;
        cur_cmd      <= cur_cmd_next;
        phase_index  <= phase_index_next;
        sub          <= sub_next;
        tick_divider <= tick_divider_next;
        shift_reg    <= shift_reg_next;
        ack_choice   <= ack_choice_next;
        ack_sample   <= ack_sample_next;
        line_drive   <= line_drive_next;
        rd_hold      <= rd_hold_next;
        res_valid    <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  logic res_done;

  always_ff @(posedge clk) begin
    if (step) begin
      res_done <= done_next;
    end
  end

  assign res.valid    = res_valid;
  assign res.scl_low  = line_drive[L_SCL];
  assign res.sda_low  = line_drive[L_SDA];
  assign res.busy_res = active;
  assign res.done_res = res_done;
  assign res.rd_byte  = rd_hold;
  assign res.ack_bit  = ack_sample;

endmodule

`default_nettype wire

// ===== tb/sv/i2c_bit_level_master_tb.sv =====
`default_nettype none

module i2c_bit_level_master_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbm_pkg::*;

  localparam int unsigned PHASES_PER_WR_BIT = 3;
  localparam int unsigned PHASES_PER_RD_BIT = 2;
  localparam int unsigned WR_BIT_PHASES = PHASES_PER_WR_BIT * BYTE_W;
  localparam int unsigned RD_BIT_PHASES = PHASES_PER_RD_BIT * BYTE_W;
  localparam int unsigned START_PHASES = 3;
  localparam int unsigned STOP_PHASES = 2;
  // data bits, then ack clock high and low
  localparam int unsigned WRITE_PHASES = WR_BIT_PHASES + 2;
  // data bits, then ack/nack bit and one quiet phase
  localparam int unsigned READ_PHASES = RD_BIT_PHASES + PHASES_PER_WR_BIT + 1;
  localparam int unsigned DIV_MAX = 32'((64'd1 << DIVIDER_BITS_DEF) - 64'd1);
  localparam int unsigned TPU_MAX = (1 << TPU_W) - 1;
  localparam int unsigned STEADY_TPU = 100;
  localparam int unsigned MAX_SHOWN = 40;
  localparam int unsigned PLAN_LEN = 22;
  localparam int SCL = 0;
  localparam int SDA = 1;

  typedef struct packed {
    logic              cmd_valid;
    cmd_e_t            mode;
    logic [BYTE_W-1:0] wr_byte;
    logic              ack_after_read;
    logic              sda_in;
  } tick_t;

  typedef struct packed {
    logic              scl_low;
    logic              sda_low;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rd_byte;
    logic              ack_bit;
  } bus_out_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [TPU_W-1:0] tpu;
    tick_t            t;
    logic [31:0]      reps;
    logic [31:0]      sda_pat;
    logic             typed;
    bus_out_t         want;
  } plan_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_TRICKLE} rx_mode_e;

  localparam bus_out_t IDLE_OUT = '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1};

  logic clk = 1'b0;
  logic rst;

  i2cbm_tick_if tk ();
  i2cbm_res_if  rs ();
  i2cbm_cfg_if  cf ();

  i2c_bit_level_master dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tk),
    .res  (rs),
    .cfg  (cf)
  );

  always #4 clk = ~clk;

  // bus engine copy
  logic              eng_active;
  cmd_e_t            eng_cmd;
  logic [4:0]        eng_phase;
  int unsigned       eng_div;
  logic [BYTE_W-1:0] eng_shift;
  logic              eng_ack_req;
  logic              eng_ack_seen;
  logic [1:0]        eng_lines;
  logic [BYTE_W-1:0] eng_rd_hold;
  logic [TPU_W-1:0]  tpu_reg;

  bus_out_t    bus_out_q[$];
  bus_out_t    oldest;
  plan_row_t   plan [PLAN_LEN];
  int unsigned errors = 0;
  int unsigned n_checked = 0;
  int unsigned ticks_sent = 0;
  int unsigned work_ticks = 0;
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};
  int unsigned burst_left = 0;
  logic        tk_up = 1'b0;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  task automatic flag(string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("MISMATCH %s", msg);
  endtask

  task automatic cmp(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] wantv);
    if (got !== wantv) begin
      flag($sformatf("result %0d: %s is %0h, expected %0h", n_checked, name, got, wantv));
    end
  endtask

  function automatic int unsigned phase_total(cmd_e_t c);
    case (c)
      CMD_START: return START_PHASES;
      CMD_STOP:  return STOP_PHASES;
      CMD_WRITE: return WRITE_PHASES;
      default:   return READ_PHASES;
    endcase
  endfunction

  // one bit on the wire: data with scl high, scl low, then hold sda low after a one
  function automatic void drive_bit_phase(int unsigned sub, logic one);
    if (sub == 0) begin
      eng_lines = '0;
      eng_lines[SDA] = !one;
    end else if (sub == 1) begin
      eng_lines[SCL] = 1'b1;
    end else if (one) begin
      eng_lines[SDA] = 1'b1;
    end
  endfunction

  function automatic void enter_phase();
    int unsigned p;
    p = eng_phase;
    case (eng_cmd)
      CMD_START: begin
        if (p == 0) eng_lines = '0;
        else if (p == 1) eng_lines[SDA] = 1'b1;
        else eng_lines[SCL] = 1'b1;
      end
      CMD_STOP: begin
        if (p == 0) eng_lines[SCL] = 1'b0;
        else eng_lines[SDA] = 1'b0;
      end
      CMD_WRITE: begin
        if (p < WR_BIT_PHASES) begin
          drive_bit_phase(p % PHASES_PER_WR_BIT, eng_shift[BYTE_W-1]);
        end else if (p == WR_BIT_PHASES) begin
          eng_lines = '0;
        end else begin
          eng_lines[SCL] = 1'b1;
        end
      end
      default: begin
        if (p < RD_BIT_PHASES) begin
          if (p % PHASES_PER_RD_BIT == 0) eng_lines = '0;
          else eng_lines[SCL] = 1'b1;
        end else if (p < RD_BIT_PHASES + PHASES_PER_WR_BIT) begin
          drive_bit_phase(p - RD_BIT_PHASES, !eng_ack_req);
        end
      end
    endcase
  endfunction

  function automatic void leave_phase(logic sda);
    int unsigned p;
    p = eng_phase;
    if (eng_cmd == CMD_WRITE) begin
      if (p < WR_BIT_PHASES && p % PHASES_PER_WR_BIT == PHASES_PER_WR_BIT - 1) begin
        eng_shift = eng_shift << 1;
      end else if (p == WR_BIT_PHASES) begin
        eng_ack_seen = sda;
      end
    end else if (eng_cmd == CMD_READ) begin
      if (p < RD_BIT_PHASES && p % PHASES_PER_RD_BIT == 0) begin
        eng_shift = {eng_shift[BYTE_W-2:0], sda};
      end
    end
  endfunction

  function automatic bus_out_t clock_engine(tick_t t);
    bus_out_t    o;
    int unsigned span;
    int unsigned nxt;
    logic        fin;
    fin = 1'b0;
    if (eng_active || t.cmd_valid) work_ticks++;
    if (!eng_active && t.cmd_valid) begin
      eng_active = 1'b1;
      eng_cmd = t.mode;
      eng_phase = '0;
      eng_div = 0;
      eng_shift = (t.mode == CMD_WRITE) ? t.wr_byte : '0;
      eng_ack_req = t.ack_after_read;
      cmd_seen[t.mode]++;
      enter_phase();
    end
    if (eng_active) begin
      span = (tpu_reg == 0) ? 1 : tpu_reg;
      nxt = eng_div + 1;
      if (nxt >= span || nxt > DIV_MAX) begin
        leave_phase(t.sda_in);
        eng_div = 0;
        eng_phase = eng_phase + 1'b1;
        if (eng_phase >= phase_total(eng_cmd)) begin
          if (eng_cmd == CMD_READ) eng_rd_hold = eng_shift;
          eng_active = 1'b0;
          eng_phase = '0;
          fin = 1'b1;
        end else begin
          enter_phase();
        end
      end else begin
        eng_div = nxt;
      end
    end
    o.scl_low = eng_lines[SCL];
    o.sda_low = eng_lines[SDA];
    o.busy = eng_active;
    o.done = fin;
    o.rd_byte = eng_rd_hold;
    o.ack_bit = eng_ack_seen;
    return o;
  endfunction

  function automatic tick_t rand_tick(logic cmd_valid);
    tick_t t;
    t.cmd_valid = cmd_valid;
    t.mode = cmd_e_t'($urandom_range(0, 3));
    t.wr_byte = BYTE_W'($urandom_range(0, 255));
    t.ack_after_read = 1'($urandom_range(0, 1));
    t.sda_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic drop_valid();
    if (tk_up) begin
      tk.valid <= 1'b0;
      tk_up = 1'b0;
    end
  endtask

  task automatic send_tick(tick_t t, logic typed, bus_out_t want);
    bus_out_t pred;
    tk.valid <= 1'b1;
    tk.cmd_valid <= t.cmd_valid;
    tk.mode <= t.mode;
    tk.wr_byte <= t.wr_byte;
    tk.ack_after_read <= t.ack_after_read;
    tk.sda_in <= t.sda_in;
    tk_up = 1'b1;
    @(posedge clk);
    while (!tk.ready) @(posedge clk);
    pred = clock_engine(t);
    bus_out_q.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  // bursts with random gaps; long phases run back to back to keep the run short
  task automatic pace();
    if (tpu_reg > STEADY_TPU) return;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      drop_valid();
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_drain();
    drop_valid();
    while (bus_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic go_idle();
    while (eng_active) begin
      send_tick(rand_tick(1'b0), 1'b0, IDLE_OUT);
      pace();
    end
    wait_drain();
  endtask

  task automatic set_tpu(logic [TPU_W-1:0] v);
    go_idle();
    cf.valid <= 1'b1;
    cf.ticks_per_unit <= v;
    @(posedge clk);
    while (!cf.ready) @(posedge clk);
    cf.valid <= 1'b0;
    tpu_reg = v;
  endtask

  // command request, then ticks until it completes; stray commands while busy
  task automatic run_cmd(cmd_e_t c);
    tick_t t;
    t = rand_tick(1'b1);
    t.mode = c;
    send_tick(t, 1'b0, IDLE_OUT);
    pace();
    while (eng_active) begin
      send_tick(rand_tick($urandom_range(0, 3) == 0), 1'b0, IDLE_OUT);
      pace();
    end
  endtask

  task automatic shake_out(logic [TPU_W-1:0] tpu, int unsigned budget);
    int unsigned stop_at;
    int unsigned n;
    set_tpu(tpu);
    stop_at = work_ticks + budget;
    while (work_ticks < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            send_tick(rand_tick(1'b0), 1'b0, IDLE_OUT);
            pace();
          end
        end
        1: run_cmd(cmd_e_t'($urandom_range(0, 3)));
        2: wait_drain();
        default: begin
          run_cmd(CMD_START);
          n = $urandom_range(1, 3);
          repeat (n) run_cmd(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ);
          if ($urandom_range(0, 7) != 0) run_cmd(CMD_STOP);
        end
      endcase
    end
  endtask

  // result side: check, then pick the next ready level
  always @(posedge clk) begin
    if (rst) begin
      rs.ready <= 1'b0;
    end else begin
      if (rs.valid && rs.ready) begin
        if (bus_out_q.size() == 0) begin
          flag($sformatf("result %0d arrived with nothing expected", n_checked));
        end else begin
          oldest = bus_out_q.pop_front();
          cmp("scl_low", BYTE_W'(rs.scl_low), BYTE_W'(oldest.scl_low));
          cmp("sda_low", BYTE_W'(rs.sda_low), BYTE_W'(oldest.sda_low));
          cmp("busy_res", BYTE_W'(rs.busy_res), BYTE_W'(oldest.busy));
          cmp("done_res", BYTE_W'(rs.done_res), BYTE_W'(oldest.done));
          cmp("rd_byte", rs.rd_byte, oldest.rd_byte);
          cmp("ack_bit", BYTE_W'(rs.ack_bit), BYTE_W'(oldest.ack_bit));
        end
        n_checked++;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(8, 90);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN: rs.ready <= 1'b1;
        RX_COIN: rs.ready <= 1'($urandom_range(0, 1));
        default: rs.ready <= (rx_tick % 4 == 0);
      endcase
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned r;
    tick_t t;
    rst = 1'b1;
    tk.valid <= 1'b0;
    tk.cmd_valid <= 1'b0;
    tk.mode <= CMD_START;
    tk.wr_byte <= '0;
    tk.ack_after_read <= 1'b0;
    tk.sda_in <= 1'b1;
    cf.valid <= 1'b0;
    cf.ticks_per_unit <= '0;
    eng_active = 1'b0;
    eng_cmd = CMD_START;
    eng_phase = '0;
    eng_div = 0;
    eng_shift = '0;
    eng_ack_req = 1'b0;
    eng_ack_seen = 1'b1;
    eng_lines = '0;
    eng_rd_hold = '0;
    tpu_reg = TPU_W'(1);

    // reps of command rows are exact command lengths at the current phase length
    plan = '{
      '{ROW_TICK, 0, '{1'b0, CMD_READ, 8'hFF, 1'b1, 1'b0}, 1, 32'hFFFF_FFFF, 1'b1, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 1, 32'h0, 1'b1, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_START, 8'h00, 1'b0, 1'b0}, 3, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_WRITE, 8'hFF, 1'b0, 1'b0}, 26, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_WRITE, 8'h00, 1'b1, 1'b0}, 26, 32'hFFFF_FFFF, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_WRITE, 8'hA5, 1'b0, 1'b0}, 26, 32'h5555_5555, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_READ, 8'h00, 1'b1, 1'b0}, 20, 32'hFFFF_FFFF, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_READ, 8'hFF, 1'b0, 1'b0}, 20, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_READ, 8'h5A, 1'b1, 1'b0}, 20, 32'hC3A5_96E1, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_STOP, 8'h00, 1'b0, 1'b0}, 2, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_STOP, 8'hFF, 1'b1, 1'b0}, 2, 32'hFFFF_FFFF, 1'b0, IDLE_OUT},
      // write with no start in front of it
      '{ROW_TICK, 0, '{1'b1, CMD_WRITE, 8'h80, 1'b0, 1'b0}, 26, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_CFG, 0, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 0, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_START, 8'h00, 1'b0, 1'b0}, 3, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_READ, 8'h00, 1'b0, 1'b0}, 20, 32'hFFFF_FFFF, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_STOP, 8'h00, 1'b0, 1'b0}, 2, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_CFG, 2, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 0, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_WRITE, 8'h3C, 1'b0, 1'b0}, 52, 32'h00F0_0F0F, 1'b0, IDLE_OUT},
      '{ROW_CFG, TPU_MAX, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 0, 32'h0, 1'b0, IDLE_OUT},
      // longest phase loaded with the bus left idle
      '{ROW_TICK, 0, '{1'b0, CMD_STOP, 8'h00, 1'b0, 1'b0}, 4, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_CFG, 40, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 0, 32'h0, 1'b0, IDLE_OUT},
      '{ROW_TICK, 0, '{1'b1, CMD_START, 8'h00, 1'b0, 1'b0}, 120, 32'h0, 1'b0, IDLE_OUT}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        set_tpu(plan[i].tpu);
      end else begin
        for (r = 0; r < plan[i].reps; r++) begin
          t = plan[i].t;
          t.sda_in = plan[i].sda_pat[r % 32];
          send_tick(t, plan[i].typed, plan[i].want);
          pace();
        end
      end
    end

    shake_out(1, 160);
    shake_out(0, 50);
    shake_out(3, 60);
    shake_out(2, 60);

    go_idle();
    repeat (8) @(posedge clk);
    if (bus_out_q.size() != 0) flag($sformatf("%0d results never came", bus_out_q.size()));

    $display("ran %0d ticks, %0d with the bus engine working, %0d results checked",
             ticks_sent, work_ticks, n_checked);
    $display("commands: %0d start, %0d stop, %0d write, %0d read; phases 0..3 and 40, %0d idle",
             cmd_seen[CMD_START], cmd_seen[CMD_STOP], cmd_seen[CMD_WRITE], cmd_seen[CMD_READ],
             TPU_MAX);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
